/* rtl/rxf_pkg.sv */
// Shared types and constants for the receive FIFO with idle-gap frame detection.
package rxf_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned LIMIT_W = 24;
    localparam int unsigned IDLE_W  = LIMIT_W + 1;

    localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RST = LIMIT_W'(150000);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_TICK = 2'd1,
        OP_POP  = 2'd2
    } t_opcode;

    // request from the control path to the byte buffer, valid on an accepted transaction
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [BYTE_W-1:0] wr_byte;
    } t_buf_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_buf_stat;

endpackage

/* rtl/rxf_if.sv */
// Channel interfaces: input transactions and result transactions.
interface rxf_in_if;
    import rxf_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface rxf_out_if #(
    parameter int unsigned CW = 11
);
    import rxf_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              pop_valid;
    logic              push_dropped;
    logic              frame_ready;
    logic [CW-1:0]     fill_level;

    modport source (output valid, output out_byte, output pop_valid, output push_dropped,
                    output frame_ready, output fill_level, input ready);
    modport sink   (input valid, input out_byte, input pop_valid, input push_dropped,
                    input frame_ready, input fill_level, output ready);
endinterface

/* rtl/rxf_buf.sv */
// Circular byte store with read/write pointers and fill count.
module rxf_buf
    import rxf_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_en,
    input  t_buf_req                     i_req,
    output t_buf_stat                    o_stat,
    output logic [$clog2(DEPTH+1)-1:0]   o_count,
    output logic [BYTE_W-1:0]            o_rd_data
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH+1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wp, n_wp;
    logic [PW-1:0]     r_rp, n_rp;
    logic [CW-1:0]     r_count, n_count;
    logic [BYTE_W-1:0] r_rd_data;
    logic              push_ok;
    logic              pop_ok;

    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);
    assign push_ok = i_req_en && i_req.push && !o_stat.full;
    assign pop_ok  = i_req_en && i_req.pop && !o_stat.empty;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (push_ok) begin
            n_wp    = (r_wp == PTR_LAST) ? '0 : r_wp + PW'(1);
            n_count = r_count + CW'(1);
        end
        if (pop_ok) begin
            n_rp    = (r_rp == PTR_LAST) ? '0 : r_rp + PW'(1);
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // push and pop never share a transaction, so the ports never collide on an entry
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_req.wr_byte;
        end
        if (pop_ok) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    assign o_count   = r_count;
    assign o_rd_data = r_rd_data;

endmodule

/* rtl/rx_fifo_with_idle_timeout_top.sv */
// Receive FIFO with idle-gap frame detection: one channel. Each input transaction is a
// push of a received byte, an idle tick or a pop, and yields one result transaction that
// reports the popped byte, a drop flag, frame-ready and the fill level after the
// transaction. A transaction may be accepted every cycle while the input is not stalled;
// its result passes through the first stage (the byte store read is registered at the
// accepting edge) and then the output register, which loads once it is free; a result
// stalled at the output holds back one further transaction before the input stalls. The
// idle limit is to be written by the user through i_cfg_we and i_cfg_wdata only while no
// transaction is in flight; the block does not enforce this. It resets to 150000 ticks.
module rx_fifo_with_idle_timeout_top
    import rxf_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [LIMIT_W-1:0]   i_cfg_wdata,
    rxf_in_if.sink               i_item,
    rxf_out_if.source            o_result
);

    localparam int unsigned CW = $clog2(DEPTH+1);

    logic [LIMIT_W-1:0] r_idle_limit;
    logic [IDLE_W-1:0]  r_idle, n_idle;

    // first stage: flags of the accepted transaction, waiting for the store read
    logic               r_s1_valid;
    logic               r_s1_pop;
    logic               r_s1_drop;

    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic               r_out_pop;
    logic               r_out_drop;
    logic               r_out_frame;
    logic [CW-1:0]      r_out_fill;

    logic               out_free;
    logic               s1_move;
    logic               accept;
    t_buf_req           buf_req;
    t_buf_stat          buf_stat;
    logic [CW-1:0]      buf_count;
    logic [BYTE_W-1:0]  buf_rd_data;
    logic               is_push;
    logic               is_pop;
    logic               is_tick;

    assign out_free     = !r_out_valid || o_result.ready;
    assign s1_move      = r_s1_valid && out_free;
    assign i_item.ready = !r_s1_valid || out_free;
    assign accept       = i_item.valid && i_item.ready;

    assign is_push = (i_item.opcode == OP_PUSH);
    assign is_pop  = (i_item.opcode == OP_POP);
    assign is_tick = (i_item.opcode == OP_TICK);

    assign buf_req.push    = is_push;
    assign buf_req.pop     = is_pop;
    assign buf_req.wr_byte = i_item.rx_byte;

    rxf_buf #(
        .DEPTH (DEPTH)
    ) u_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req_en  (accept),
        .i_req     (buf_req),
        .o_stat    (buf_stat),
        .o_count   (buf_count),
        .o_rd_data (buf_rd_data)
    );

    // counter saturates one above the limit
    always_comb begin
        n_idle = r_idle;
        if (accept && is_push) begin
            n_idle = '0;
        end else if (accept && is_tick && (r_idle <= {1'b0, r_idle_limit})) begin
            n_idle = r_idle + IDLE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit <= IDLE_LIMIT_RST;
            r_idle       <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_idle_limit <= i_cfg_wdata;
            end
            r_idle <= n_idle;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pop  <= is_pop && !buf_stat.empty;
            r_s1_drop <= is_push && buf_stat.full;
        end
        // state seen here is the state after the first-stage transaction
        if (s1_move) begin
            r_out_byte  <= r_s1_pop ? buf_rd_data : '0;
            r_out_pop   <= r_s1_pop;
            r_out_drop  <= r_s1_drop;
            r_out_frame <= !buf_stat.empty && (r_idle > {1'b0, r_idle_limit});
            r_out_fill  <= buf_count;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.out_byte     = r_out_byte;
    assign o_result.pop_valid    = r_out_pop;
    assign o_result.push_dropped = r_out_drop;
    assign o_result.frame_ready  = r_out_frame;
    assign o_result.fill_level   = r_out_fill;

endmodule

/* rtl/rxf_checker.sv */
// Port-level checks for the receive FIFO top level, bound in below.
module rxf_checker
    import rxf_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic [BYTE_W-1:0]          i_out_byte,
    input logic                       i_pop_valid,
    input logic                       i_push_dropped,
    input logic                       i_frame_ready,
    input logic [$clog2(DEPTH+1)-1:0] i_fill_level
);

    localparam int unsigned CW = $clog2(DEPTH+1);

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_pop_valid && i_push_dropped))
        else $error("pop and drop flagged in one transaction");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_pop_valid) |-> (i_out_byte == '0))
        else $error("byte non-zero without a pop");

    a_frame_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_frame_ready) |-> (i_fill_level != '0))
        else $error("frame ready with empty FIFO");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_fill_level <= CW'(DEPTH)))
        else $error("fill level beyond depth");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

endmodule

bind rx_fifo_with_idle_timeout_top rxf_checker #(
    .DEPTH (DEPTH)
) u_rxf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_result.valid),
    .i_out_byte     (o_result.out_byte),
    .i_pop_valid    (o_result.pop_valid),
    .i_push_dropped (o_result.push_dropped),
    .i_frame_ready  (o_result.frame_ready),
    .i_fill_level   (o_result.fill_level)
);

/* tb/tb_rx_fifo_with_idle_timeout_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the receive FIFO with idle-gap frame detection.
module tb_rx_fifo_with_idle_timeout_top;
    import rxf_pkg::*;

    localparam int unsigned DEPTH       = 1024;
    localparam int unsigned PTR_W       = $clog2(DEPTH);
    localparam int unsigned FILL_W      = PTR_W + 1;
    localparam int unsigned HOLD_CYCLES = 300;

    localparam logic [OP_W-1:0]    OP_NONE   = 2'd3;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [BYTE_W-1:0] rx_byte;
    } t_rx_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              pop_valid;
        logic              push_dropped;
        logic              frame_ready;
        logic [FILL_W-1:0] fill_level;
    } t_rx_status;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [LIMIT_W-1:0] i_cfg_wdata;

    rxf_in_if                 item_ch ();
    rxf_out_if #(.CW(FILL_W)) result_ch ();

    rx_fifo_with_idle_timeout_top #(
        .DEPTH (DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    // local copy of the FIFO and idle counter
    logic [BYTE_W-1:0]  byte_mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr;
    logic [PTR_W-1:0]   rd_ptr;
    logic [FILL_W-1:0]  held_cnt;
    logic [IDLE_W-1:0]  idle_cnt;
    logic [LIMIT_W-1:0] idle_limit;

    t_rx_item    pending_items [$];
    t_rx_status  pending_status [$];
    t_rx_item    next_item;
    int unsigned mismatch_count;
    int unsigned queued_items;
    int unsigned src_gap;
    int unsigned snk_gap;
    int unsigned hold_left;
    logic        hold_go;
    bit          gaps_on;

    always #6 i_clk = ~i_clk;

    function automatic t_rx_status step_rx_fifo(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data);
        t_rx_status st;
        st = '0;
        case (op)
            OP_PUSH: begin
                if (held_cnt < DEPTH) begin
                    byte_mem[wr_ptr] = data;
                    wr_ptr   = wr_ptr + 1'b1;
                    held_cnt = held_cnt + 1'b1;
                end else begin
                    st.push_dropped = 1'b1;
                end
                idle_cnt = '0;
            end
            OP_TICK: begin
                // saturates one above the limit, also after the limit was lowered
                if (idle_cnt <= idle_limit)
                    idle_cnt = idle_cnt + 1'b1;
            end
            OP_POP: begin
                if (held_cnt != 0) begin
                    st.out_byte  = byte_mem[rd_ptr];
                    st.pop_valid = 1'b1;
                    rd_ptr   = rd_ptr + 1'b1;
                    held_cnt = held_cnt - 1'b1;
                end
            end
            default: ;
        endcase
        st.frame_ready = (held_cnt != 0) && (idle_cnt > idle_limit);
        st.fill_level  = held_cnt;
        return st;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic check_status();
        t_rx_status want;
        if (pending_status.size() == 0) begin
            $error("result transaction with no prediction waiting");
            mismatch_count++;
            return;
        end
        want = pending_status.pop_front();
        compare_field("out_byte", want.out_byte, result_ch.out_byte);
        compare_field("pop_valid", want.pop_valid, result_ch.pop_valid);
        compare_field("push_dropped", want.push_dropped, result_ch.push_dropped);
        compare_field("frame_ready", want.frame_ready, result_ch.frame_ready);
        compare_field("fill_level", want.fill_level, result_ch.fill_level);
    endtask

    // sender: predicts on each accepted transaction, then offers the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (item_ch.valid && item_ch.ready)
                pending_status.push_back(step_rx_fifo(item_ch.opcode, item_ch.rx_byte));
            if (!item_ch.valid || item_ch.ready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    item_ch.valid <= 1'b0;
                end else if (gaps_on && $urandom_range(0, 15) == 0) begin
                    src_gap = $urandom_range(0, 10);
                    item_ch.valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    next_item = pending_items.pop_front();
                    item_ch.valid   <= 1'b1;
                    item_ch.opcode  <= next_item.opcode;
                    item_ch.rx_byte <= next_item.rx_byte;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_left <= 0;
        else if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // receiver: checks each accepted result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (result_ch.valid && result_ch.ready)
                check_status();
            if (hold_left != 0) begin
                result_ch.ready <= 1'b0;
            end else if (snk_gap != 0) begin
                snk_gap--;
                result_ch.ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 15) == 0) begin
                snk_gap = $urandom_range(0, 10);
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    task automatic queue_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data);
        t_rx_item it;
        it.opcode  = op;
        it.rx_byte = data;
        pending_items.push_back(it);
        queued_items++;
    endtask

    task automatic queue_noise();
        queue_item(OP_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
    endtask

    // one frame: bytes, an idle gap around the limit, then pops
    task automatic queue_frame(input bit draining);
        int unsigned nbytes;
        int unsigned nticks;
        int unsigned npops;
        nbytes = $urandom_range(1, draining ? 4 : 12);
        nticks = $urandom_range(0, (idle_limit < 16) ? idle_limit + 3 : 16);
        npops  = draining ? nbytes + $urandom_range(10, 30) : $urandom_range(0, nbytes + 2);
        for (int unsigned i = 0; i < nbytes; i++) begin
            queue_item(OP_PUSH, BYTE_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 15) == 0)
                queue_noise();
        end
        for (int unsigned i = 0; i < nticks; i++) begin
            queue_item(OP_TICK, BYTE_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 31) == 0)
                queue_noise();
        end
        for (int unsigned i = 0; i < npops; i++)
            queue_item(OP_POP, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_items.size() != 0 || item_ch.valid || pending_status.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        idle_limit = value;
        @(negedge i_clk);
    endtask

    initial begin
        int unsigned target;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        hold_go           = 1'b0;
        gaps_on           = 1'b1;
        item_ch.valid     = 1'b0;
        item_ch.opcode    = OP_PUSH;
        item_ch.rx_byte   = '0;
        result_ch.ready   = 1'b0;
        mismatch_count    = 0;
        queued_items      = 0;
        wr_ptr            = '0;
        rd_ptr            = '0;
        held_cnt          = '0;
        idle_cnt          = '0;
        idle_limit        = IDLE_LIMIT_RST;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // limit at its reset value: basic push/pop, unused opcode, pop when empty
        queue_item(OP_PUSH, 8'h00);
        queue_item(OP_PUSH, 8'hFF);
        queue_item(OP_TICK, 8'h3C);
        queue_item(OP_NONE, 8'hAA);
        queue_item(OP_POP, 8'h00);
        queue_item(OP_POP, 8'h00);
        queue_item(OP_POP, 8'hFF);
        queue_item(OP_TICK, 8'h00);
        queue_item(OP_PUSH, 8'h55);
        queue_item(OP_POP, 8'h00);

        // zero limit: one tick completes the frame, a push clears it again
        write_limit('0);
        queue_item(OP_PUSH, 8'h81);
        queue_item(OP_TICK, 8'h00);
        queue_item(OP_TICK, 8'h00);
        queue_item(OP_POP, 8'h00);
        queue_item(OP_POP, 8'h00);
        queue_item(OP_PUSH, 8'h7E);
        queue_item(OP_PUSH, 8'h01);
        queue_item(OP_TICK, 8'h00);
        queue_item(OP_PUSH, 8'h80);
        queue_item(OP_POP, 8'h00);
        target = queued_items + 220;
        while (queued_items < target)
            queue_frame(1'b0);

        // count saturated, then the limit lowered below it and raised above it
        write_limit(24'd6);
        queue_item(OP_PUSH, 8'h12);
        queue_item(OP_PUSH, 8'h34);
        repeat (8) queue_item(OP_TICK, 8'h00);
        write_limit(24'd2);
        queue_item(OP_TICK, 8'h00);
        write_limit(24'd20);
        queue_item(OP_TICK, 8'h00);
        queue_item(OP_POP, 8'h00);
        queue_item(OP_POP, 8'h00);
        queue_item(OP_POP, 8'h00);
        write_limit(LIMIT_W'($urandom_range(1, 10)));
        target = queued_items + 150;
        while (queued_items < target)
            queue_frame(1'b0);

        // widest limit: fill past full while the receiver holds off for a long stretch
        write_limit(LIMIT_MAX);
        for (int unsigned i = 0; i < DEPTH - held_cnt + 6; i++) begin
            queue_item(OP_PUSH, BYTE_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 15) == 0)
                queue_item(OP_TICK, BYTE_W'($urandom_range(0, 255)));
        end
        @(posedge i_clk);
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;

        // pop-heavy frames, no idling on either side
        write_limit(24'd3);
        gaps_on = 1'b0;
        target  = queued_items + 200;
        while (queued_items < target)
            queue_frame(1'b1);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
